@@ src/b64d_pkg.sv @@
// b64d_pkg: shared types, constants and the character classifier of the
// base64 stream decoder. No dependencies.
`default_nettype none

package b64d_pkg;

	localparam logic [7:0] CLS_SPACE = 8'h80;
	localparam logic [7:0] CLS_BAD   = 8'hff;
	localparam logic [7:0] CLS_PAD   = 8'h40;
	localparam logic [7:0] CLS_PLUS  = 8'h3e;
	localparam logic [7:0] CLS_SLASH = 8'h3f;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5a;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SLASH   = 8'h2f;
	localparam logic [7:0] CH_EQUALS  = 8'h3d;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0a;
	localparam logic [7:0] CH_FF      = 8'h0c;
	localparam logic [7:0] CH_CR      = 8'h0d;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// one decoded group: up to three bytes; cnt 0 is a bare end status
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      cnt;
		logic            last;
		logic            err;
	} rec_t;

	function automatic logic [7:0] classify(input logic [7:0] c);
		logic [7:0] v;
		if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
			v = c - CH_UPPER_A;
		else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
			v = c - CH_LOWER_A + 8'd26;
		else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
			v = c - CH_DIGIT_0 + 8'd52;
		else if (c == CH_PLUS)
			v = CLS_PLUS;
		else if (c == CH_SLASH)
			v = CLS_SLASH;
		else if (c == CH_EQUALS)
			v = CLS_PAD;
		else if (c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR || c == CH_SPACE)
			v = CLS_SPACE;
		else
			v = CLS_BAD;
		return v;
	endfunction

endpackage

`default_nettype wire

@@ src/b64d_if.sv @@
// b64d_if: valid/ready channel interfaces for the character input and the
// decoded byte output. No dependencies.
`default_nettype none

interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;

	modport source (output valid, output in_char, output in_last, input ready);
	modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       out_last;
	logic       out_error;

	modport source (output valid, output out_byte, output has_byte, output out_last,
		output out_error, input ready);
	modport sink   (input valid, input out_byte, input has_byte, input out_last,
		input out_error, output ready);
endinterface

`default_nettype wire

@@ src/b64d_front.sv @@
// b64d_front: accepts characters, classifies them, keeps the group state
// and pushes one record per group or message end. Uses b64d_pkg, b64d_if.
`default_nettype none

module b64d_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	b64d_in_if.sink          text,
	input  wire logic        full,
	output logic             push,
	output b64d_pkg::rec_t   rec
);

	logic [17:0] buf_q, buf_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        twp_q, twp_d;
	logic        pgd_q, pgd_d;
	logic        err_q, err_d;
	logic [7:0]  v;
	logic [1:0]  n;
	logic        accept;

	assign text.ready = !full;
	assign accept     = text.valid && !full;

	always_comb begin
		v     = b64d_pkg::classify(text.in_char);
		buf_d = buf_q;
		cnt_d = cnt_q;
		twp_d = twp_q;
		pgd_d = pgd_q;
		err_d = err_q;
		n     = 2'd0;
		if (v != b64d_pkg::CLS_SPACE && !err_q) begin
			if (pgd_q || v == b64d_pkg::CLS_BAD) begin
				err_d = 1'b1;
			end else if (v == b64d_pkg::CLS_PAD) begin
				if (cnt_q < 2'd2) begin
					err_d = 1'b1;
				end else if (cnt_q == 2'd2) begin
					buf_d = {buf_q[11:0], 6'd0};
					twp_d = 1'b1;
					cnt_d = 2'd3;
				end else begin
					n     = twp_q ? 2'd1 : 2'd2;
					buf_d = '0;
					cnt_d = 2'd0;
					twp_d = 1'b0;
					pgd_d = 1'b1;
				end
			end else if (cnt_q == 2'd3) begin
				if (twp_q) begin
					err_d = 1'b1;
				end else begin
					n     = 2'd3;
					buf_d = '0;
					cnt_d = 2'd0;
				end
			end else begin
				buf_d = {buf_q[11:0], v[5:0]};
				cnt_d = cnt_q + 2'd1;
			end
		end
		if (text.in_last && cnt_d != 2'd0)
			err_d = 1'b1;

		rec.bytes[0] = buf_q[17:10];
		rec.bytes[1] = buf_q[9:2];
		rec.bytes[2] = {buf_q[1:0], v[5:0]};
		rec.cnt      = n;
		rec.last     = text.in_last;
		rec.err      = text.in_last && err_d;
		push         = accept && (n != 2'd0 || text.in_last);

		if (text.in_last) begin
			buf_d = '0;
			cnt_d = 2'd0;
			twp_d = 1'b0;
			pgd_d = 1'b0;
			err_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= 2'd0;
			twp_q <= 1'b0;
			pgd_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			buf_q <= buf_d;
			cnt_q <= cnt_d;
			twp_q <= twp_d;
			pgd_q <= pgd_d;
			err_q <= err_d;
		end
	end

endmodule

`default_nettype wire

@@ src/b64d_queue.sv @@
// b64d_queue: small FIFO of group records between front and back.
// Uses b64d_pkg.
`default_nettype none

module b64d_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire b64d_pkg::rec_t  wr_rec,
	output logic                 full,
	input  wire logic            pop,
	output b64d_pkg::rec_t       rd_rec,
	output logic                 empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64d_pkg::rec_t mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] fill_q;
	logic do_push, do_pop;

	assign full    = fill_q == CNT_W'(DEPTH);
	assign empty   = fill_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_rec  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			fill_q <= '0;
		end else begin
			if (do_push)
				wp_q <= (wp_q == PTR_W'(DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			if (do_pop)
				rp_q <= (rp_q == PTR_W'(DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			if (do_push && !do_pop)
				fill_q <= fill_q + CNT_W'(1);
			else if (do_pop && !do_push)
				fill_q <= fill_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

@@ src/b64d_back.sv @@
// b64d_back: walks the head record of the queue and emits one byte or end
// status per transaction. Uses b64d_pkg, b64d_if.
`default_nettype none

module b64d_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire b64d_pkg::rec_t  rec,
	input  wire logic            empty,
	output logic                 pop,
	b64d_out_if.source           data
);

	logic [1:0] idx_q;
	logic       fin;
	logic       fire;
	logic       has;
	logic [7:0] sel;

	assign has  = rec.cnt != 2'd0;
	assign fin  = !has || (idx_q == rec.cnt - 2'd1);
	assign fire = data.valid && data.ready;
	assign pop  = fire && fin;

	always_comb begin
		case (idx_q)
			2'd0:    sel = rec.bytes[0];
			2'd1:    sel = rec.bytes[1];
			default: sel = rec.bytes[2];
		endcase
	end

	assign data.valid     = !empty;
	assign data.out_byte  = has ? sel : 8'd0;
	assign data.has_byte  = has;
	assign data.out_last  = fin && rec.last;
	assign data.out_error = fin && rec.last && rec.err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 2'd0;
		else if (pop)
			idx_q <= 2'd0;
		else if (fire)
			idx_q <= idx_q + 2'd1;
	end

endmodule

`default_nettype wire

@@ src/base64_stream_decoder_unit.sv @@
// base64_stream_decoder_unit: top level of the streaming base64 decoder.
// Uses b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back.
//
//   channel | dir | payload                                  | handshake
//   text    | in  | in_char[7:0], in_last                    | valid/ready
//   data    | out | out_byte[7:0], has_byte, out_last, out_error | valid/ready
//
// The front takes one character per cycle and decodes it in that cycle;
// a character that completes a group, or ends the message, queues one record.
// The back emits one result per cycle from the queue head while data.ready
// is high: up to three per group; output bandwidth sets the sustained rate.
// Input stalls only when QUEUE_DEPTH records are waiting. Async reset clears
// the group state, queue pointers and the byte index.
`default_nettype none

module base64_stream_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	b64d_in_if.sink     text,
	b64d_out_if.source  data
);

	b64d_pkg::rec_t wr_rec, rd_rec;
	logic push, full, pop, empty;

	b64d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text),
		.full   (full),
		.push   (push),
		.rec    (wr_rec)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.full   (full),
		.pop    (pop),
		.rd_rec (rd_rec),
		.empty  (empty)
	);

	b64d_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rec    (rd_rec),
		.empty  (empty),
		.pop    (pop),
		.data   (data)
	);

endmodule

`default_nettype wire

@@ bench/b64d_decode_checker.sv @@
`timescale 1ns / 100ps
// b64d_decode_checker: watches both channels of the base64 stream decoder, predicts
// the decoded bytes and end status, and compares each output transaction.
// Depends on b64d_pkg and b64d_if.

module b64d_decode_checker (
	input  logic clk,
	input  logic arst_n,
	b64d_in_if   txt,
	b64d_out_if  dat,
	output int   fail_cnt,
	output int   waiting
);

	typedef struct packed {
		logic [7:0] dbyte;
		logic       has;
		logic       last;
		logic       err;
	} dec_res_t;

	dec_res_t    exp_q[$];
	logic [17:0] sext_buf;
	logic [1:0]  grp_cnt;
	logic        third_pad;
	logic        pad_done;
	logic        err_seen;

	task automatic report(input string what);
		fail_cnt++;
		if (fail_cnt <= 40)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	function automatic logic [7:0] sextet_of(input logic [7:0] c);
		logic [7:0] v;
		v = b64d_pkg::CLS_BAD;
		if (c >= b64d_pkg::CH_UPPER_A && c <= b64d_pkg::CH_UPPER_Z)
			v = c - b64d_pkg::CH_UPPER_A;
		if (c >= b64d_pkg::CH_LOWER_A && c <= b64d_pkg::CH_LOWER_Z)
			v = c - b64d_pkg::CH_LOWER_A + 8'd26;
		if (c >= b64d_pkg::CH_DIGIT_0 && c <= b64d_pkg::CH_DIGIT_9)
			v = c - b64d_pkg::CH_DIGIT_0 + 8'd52;
		case (c)
			b64d_pkg::CH_PLUS:   v = b64d_pkg::CLS_PLUS;
			b64d_pkg::CH_SLASH:  v = b64d_pkg::CLS_SLASH;
			b64d_pkg::CH_EQUALS: v = b64d_pkg::CLS_PAD;
			b64d_pkg::CH_TAB, b64d_pkg::CH_LF, b64d_pkg::CH_FF, b64d_pkg::CH_CR,
			b64d_pkg::CH_SPACE: v = b64d_pkg::CLS_SPACE;
			default: ;
		endcase
		return v;
	endfunction

	function automatic void clear_group();
		sext_buf  = '0;
		grp_cnt   = '0;
		third_pad = 1'b0;
	endfunction

	function automatic void decode_char(input logic [7:0] c, input logic fin);
		logic [7:0] v;
		int         first;
		dec_res_t   tail;
		first = exp_q.size();
		v = sextet_of(c);
		if (v != b64d_pkg::CLS_SPACE && !err_seen) begin
			if (pad_done || v == b64d_pkg::CLS_BAD) begin
				err_seen = 1'b1;
			end else if (v == b64d_pkg::CLS_PAD) begin
				if (grp_cnt < 2'd2) begin
					err_seen = 1'b1;
				end else if (grp_cnt == 2'd2) begin
					sext_buf  = {sext_buf[11:0], 6'd0};
					third_pad = 1'b1;
					grp_cnt   = 2'd3;
				end else begin
					exp_q.push_back({sext_buf[17:10], 1'b1, 1'b0, 1'b0});
					if (!third_pad)
						exp_q.push_back({sext_buf[9:2], 1'b1, 1'b0, 1'b0});
					clear_group();
					pad_done = 1'b1;
				end
			end else if (grp_cnt == 2'd3) begin
				if (third_pad) begin
					err_seen = 1'b1;
				end else begin
					exp_q.push_back({sext_buf[17:10], 1'b1, 1'b0, 1'b0});
					exp_q.push_back({sext_buf[9:2], 1'b1, 1'b0, 1'b0});
					exp_q.push_back({sext_buf[1:0], v[5:0], 1'b1, 1'b0, 1'b0});
					clear_group();
				end
			end else begin
				sext_buf = {sext_buf[11:0], v[5:0]};
				grp_cnt  = grp_cnt + 2'd1;
			end
		end
		if (fin) begin
			if (grp_cnt != 2'd0)
				err_seen = 1'b1;
			if (exp_q.size() == first)
				exp_q.push_back({8'h00, 1'b0, 1'b0, 1'b0});
			tail = exp_q.pop_back();
			tail.last = 1'b1;
			tail.err  = err_seen;
			exp_q.push_back(tail);
			clear_group();
			pad_done = 1'b0;
			err_seen = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dec_res_t want;
		if (!arst_n) begin
			exp_q.delete();
			clear_group();
			pad_done = 1'b0;
			err_seen = 1'b0;
			fail_cnt = 0;
			waiting  = 0;
		end else begin
			if (txt.valid && txt.ready)
				decode_char(txt.in_char, txt.in_last);
			if (dat.valid && dat.ready) begin
				if (exp_q.size() == 0) begin
					report($sformatf("unexpected transaction byte=%h has=%b last=%b err=%b",
						dat.out_byte, dat.has_byte, dat.out_last, dat.out_error));
				end else begin
					want = exp_q.pop_front();
					if (dat.out_byte !== want.dbyte)
						report($sformatf("out_byte %h, want %h", dat.out_byte, want.dbyte));
					if (dat.has_byte !== want.has)
						report($sformatf("has_byte %b, want %b", dat.has_byte, want.has));
					if (dat.out_last !== want.last)
						report($sformatf("out_last %b, want %b", dat.out_last, want.last));
					if (dat.out_error !== want.err)
						report($sformatf("out_error %b, want %b", dat.out_error, want.err));
				end
			end
			waiting = exp_q.size();
		end
	end

endmodule

@@ bench/base64_stream_decoder_unit_tb.sv @@
`timescale 1ns / 100ps
// base64_stream_decoder_unit_tb: drives character messages into the decoder, with
// random gaps and output stalls, and gives the verdict. Depends on b64d_pkg,
// b64d_if, b64d_decode_checker and base64_stream_decoder_unit.

module base64_stream_decoder_unit_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 180;
	localparam int DRAIN       = 32;

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   sent;
	int   cycles;
	bit   tx_fast;
	logic [7:0] msg_q[$];

	b64d_in_if  text_ch ();
	b64d_out_if data_ch ();

	base64_stream_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.data   (data_ch)
	);

	b64d_decode_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.txt      (text_ch),
		.dat      (data_ch),
		.fail_cnt (fails),
		.waiting  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [7:0] b64_char(input int v);
		if (v < 26)
			return 8'(b64d_pkg::CH_UPPER_A + v);
		if (v < 52)
			return 8'(b64d_pkg::CH_LOWER_A + (v - 26));
		if (v < 62)
			return 8'(b64d_pkg::CH_DIGIT_0 + (v - 52));
		return (v == 62) ? b64d_pkg::CH_PLUS : b64d_pkg::CH_SLASH;
	endfunction

	function automatic logic [7:0] ws_char();
		case ($urandom_range(0, 4))
			0:       return b64d_pkg::CH_TAB;
			1:       return b64d_pkg::CH_LF;
			2:       return b64d_pkg::CH_FF;
			3:       return b64d_pkg::CH_CR;
			default: return b64d_pkg::CH_SPACE;
		endcase
	endfunction

	function automatic void push_data();
		if ($urandom_range(0, 7) == 0)
			msg_q.push_back(ws_char());
		msg_q.push_back(b64_char($urandom_range(0, 63)));
	endfunction

	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_ch.valid   <= 1'b1;
		text_ch.in_char <= c;
		text_ch.in_last <= fin;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	task automatic send_msg();
		for (int i = 0; i < msg_q.size(); i++)
			send_char(msg_q[i], i == msg_q.size() - 1);
	endtask

	// mostly well-formed messages, some corrupted, some pure noise
	task automatic build_msg();
		int kind;
		int pos;
		msg_q.delete();
		kind = $urandom_range(0, 19);
		if (kind < 2) begin
			repeat ($urandom_range(1, 6))
				msg_q.push_back(8'($urandom_range(0, 255)));
			return;
		end
		repeat ($urandom_range(0, 3))
			repeat (4) push_data();
		case ($urandom_range(0, 2))
			1: begin
				repeat (3) push_data();
				msg_q.push_back(b64d_pkg::CH_EQUALS);
			end
			2: begin
				repeat (2) push_data();
				msg_q.push_back(b64d_pkg::CH_EQUALS);
				msg_q.push_back(b64d_pkg::CH_EQUALS);
			end
			default: ;
		endcase
		if ($urandom_range(0, 5) == 0)
			msg_q.push_back(ws_char());
		if (msg_q.size() == 0)
			msg_q.push_back(ws_char());
		if (kind < 7) begin
			pos = $urandom_range(0, msg_q.size() - 1);
			case (kind)
				2, 3: msg_q[pos] = 8'($urandom_range(0, 255));
				4, 5: msg_q.insert(pos, b64d_pkg::CH_EQUALS);
				default: begin
					if (msg_q.size() > 1)
						void'(msg_q.pop_back());
					else
						msg_q[0] = b64_char($urandom_range(0, 63));
				end
			endcase
		end
	endtask

	// output side: random stalls, stall-free runs and one long hold-off
	initial begin
		int  w;
		int  got;
		bit  held;
		bit  fast;
		got  = 0;
		held = 1'b0;
		fast = 1'b0;
		data_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (got % 32 == 0)
				fast = ($urandom_range(0, 2) == 0);
			if (got == 40 && !held) begin
				w = HOLD_CYCLES;
				held = 1'b1;
			end else begin
				w = fast ? 0 : $urandom_range(0, 7);
			end
			if (w > 0) begin
				data_ch.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			data_ch.ready <= 1'b1;
			@(posedge clk);
			while (!data_ch.valid)
				@(posedge clk);
			@(negedge clk);
			got++;
		end
	end

	initial begin
		arst_n          = 1'b0;
		sent            = 0;
		tx_fast         = 1'b0;
		text_ch.valid   = 1'b0;
		text_ch.in_char = 8'h00;
		text_ch.in_last = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_text("AA/+");
		send_text("QR==Z");
		send_text("QUJ=\t");
		send_text(" ");
		send_text("A=");
		send_text("QQ=A");
		send_char(8'h0b, 1'b0);
		send_char(8'hff, 1'b1);
		send_char(8'h80, 1'b0);
		send_char(8'h00, 1'b1);
		send_text("Zm9");

		while (sent < RAND_ITEMS) begin
			tx_fast = ($urandom_range(0, 3) == 0);
			build_msg();
			send_msg();
		end
		text_ch.valid <= 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
src/b64d_pkg.sv
src/b64d_if.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_stream_decoder_unit.sv
bench/b64d_decode_checker.sv
bench/base64_stream_decoder_unit_tb.sv
